/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/kop_pkg.sv */
// ----------------------------------------------------------------------------
// kop_pkg
// Types, fixed-point constants and helper functions of the orbit solver.
// ----------------------------------------------------------------------------
package kop_pkg;

  localparam int FRAC_BITS    = 24;
  localparam int MAX_ITER_DEF = 30;

  // field and datapath widths
  localparam int TW       = 32;              // time value
  localparam int ECCW     = 24;              // eccentricity
  localparam int AXW      = 31;              // axis / rate / offset registers
  localparam int TOLW     = 24;
  localparam int CFGW     = 31;
  localparam int AW       = 27;              // wrapped angle
  localparam int NW       = 30;              // residual / angle sums
  localparam int CW       = 26;              // sin, cos in Q.F
  localparam int DENW     = 26;              // Newton denominator
  localparam int MAGW     = 27;              // residual magnitude
  localparam int DVW      = MAGW + FRAC_BITS; // dividend bits
  localparam int QMW      = 27;              // quotient modulo two pi
  localparam int MODW     = 43;              // mean anomaly remainder
  localparam int CRW      = 34;              // CORDIC x, y, z
  localparam int CORDIC_N = 32;
  localparam int PRW      = 58;              // serial product accumulator
  localparam int OUTW     = 104;

  // pi and derived moduli
  localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;
  localparam logic [63:0] PI_F_U = (PI_Q61 + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS);
  localparam logic [63:0] TWO_U  = PI_F_U << 1;
  localparam logic [63:0] MOD_U  = (PI_Q61 + (64'd1 << (43 - FRAC_BITS))) >> (44 - FRAC_BITS);
  localparam logic [63:0] PI30_U = (PI_Q61 + (64'd1 << 30)) >> 31;
  localparam logic [63:0] HALF_U = (PI_Q61 + (64'd1 << 31)) >> 32;
  localparam logic [63:0] MOD2_U = MOD_U << 1;

  localparam logic signed [NW-1:0]  PI_S    = signed'(PI_F_U[NW-1:0]);
  localparam logic signed [NW-1:0]  TWO_S   = signed'(TWO_U[NW-1:0]);
  localparam logic signed [AW-1:0]  PI_A    = signed'(PI_F_U[AW-1:0]);
  localparam logic        [QMW:0]   QM_TWO  = TWO_U[QMW:0];
  localparam logic        [MODW+1:0] MOD_C  = MOD_U[MODW+1:0];
  localparam logic        [MODW+1:0] MOD2_C = MOD2_U[MODW+1:0];
  localparam logic signed [CRW-1:0] PI30_S  = signed'(PI30_U[CRW-1:0]);
  localparam logic signed [CRW-1:0] HALF_S  = signed'(HALF_U[CRW-1:0]);
  localparam logic signed [CRW-1:0] GAIN_S  = 34'sd652032874;
  localparam logic signed [NW-1:0]  ONE_S   = 30'sd1 <<< FRAC_BITS;

  // arctangent of 2^-i in unsigned Q0.30
  localparam logic [29:0] ATAN_TAB [CORDIC_N] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76, 30'h01FFD55B,
    30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
    30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF, 30'h00003FFF, 30'h00001FFF,
    30'h00000FFF, 30'h000007FF, 30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F,
    30'h0000003F, 30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
    30'h00000001, 30'h00000000
  };

  // register indexes
  typedef enum logic [2:0] {
    REG_ECC  = 3'd0,
    REG_MM   = 3'd1,
    REG_SA   = 3'd2,
    REG_SB   = 3'd3,
    REG_FO   = 3'd4,
    REG_TOL  = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MMOD, ST_MWRAP, ST_CINIT, ST_CORD, ST_CFIN, ST_MUL,
    ST_EVAL, ST_DIV, ST_UPD, ST_XY, ST_SAT, ST_DONE
  } st_t;

  // Reduce an angle below three pi in magnitude into (-pi, pi]
  function automatic logic signed [AW-1:0] wrap_angle(input logic signed [NW-1:0] v);
    logic signed [NW-1:0] r;
    if (v > PI_S)
      r = v - TWO_S;
    else if (v <= -PI_S)
      r = v + TWO_S;
    else
      r = v;
    return r[AW-1:0];
  endfunction

  // Clamp a CORDIC output to plus or minus one
  function automatic logic signed [CW-1:0] clamp_one(input logic signed [CRW-7:0] v);
    logic signed [CRW-7:0] one;
    one = (CRW-6)'(1) <<< FRAC_BITS;
    if (v > one)
      return one[CW-1:0];
    else if (v < -one)
      return CW'(-one);
    else
      return v[CW-1:0];
  endfunction

  // Saturate to 32-bit signed
  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sh07FFFFFFF)
      return 32'h7FFFFFFF;
    else if (v < -35'sh080000000)
      return 32'h80000000;
    else
      return v[31:0];
  endfunction

endpackage

/* hdl/kepler_orbit_position.sv */
// ----------------------------------------------------------------------------
// kepler_orbit_position
// Orbit position from time by a Newton solve of Kepler's equation.
//
// Input stream (in_*): one word per time value. Output stream (out_*): one
// word per input with x, y, the eccentric anomaly, the step count and a
// converged flag. Configuration is to be written through cfg_* only while
// idle; the block itself does not enforce this. Per item the solver takes
// N Newton steps, N from 1 to MAX_ITER. The mean anomaly is formed one time
// bit a cycle; each step runs a bit-serial divider, a one-iteration-per-cycle
// CORDIC and two bit-serial multipliers, which form the final x, y too.
// One item is in work at a time; in_tready is high while the solver is idle.
// The result sits in an output register, so the next item is taken while it
// waits; a result that finds that register still full holds the solver.
// Reset restores the register defaults and sets the start anomaly to zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kepler_orbit_position
  import kop_pkg::*;
#(
  parameter int MAX_ITER = MAX_ITER_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [TW-1:0]   in_tdata,   // [31:0] time_value
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [OUTW-1:0] out_tdata,  // [31:0] pos_x, [63:32] pos_y,
                                      // [90:64] anomaly, [95:91] steps_used,
                                      // [96] converged, rest zero
  input  logic            cfg_we,
  input  logic [2:0]      cfg_addr,
  input  logic [CFGW-1:0] cfg_wdata
);

  localparam int SW        = $clog2(MAX_ITER + 1);
  localparam int STEPS_CAP = (MAX_ITER > 31) ? 31 : MAX_ITER;

  st_t state_r, state_nxt;
  logic [5:0] cnt_r;

  // configuration
  logic [ECCW-1:0] ecc_r;
  logic [AXW-1:0]  mm_r, sa_r, sb_r, fo_r;
  logic [TOLW-1:0] tol_r;

  // datapath
  logic [TW-1:0]            tv_r;
  logic [MODW-1:0]          mr_r;
  logic signed [AW-1:0]     m_r, ea_r, last_r;
  logic signed [CRW-1:0]    x_r, y_r, z_r;
  logic                     flip_r;
  logic signed [CW-1:0]     s_r, c_r;
  logic [AXW-1:0]           mp0_r, mp1_r;
  logic signed [PRW-1:0]    acc0_r, acc1_r;
  logic [DENW-1:0]          den_r, rem_r;
  logic                     neg_r;
  logic [DVW-1:0]           dv_r;
  logic [QMW-1:0]           qm_r;
  logic [SW-1:0]            steps_r;
  logic                     conv_r;
  logic [31:0]              px_r, py_r;
  logic                     ov_r;
  logic [OUTW-1:0]          od_r;

  logic in_acc, out_acc, out_load;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = ov_r && out_tready;
  assign out_load   = (state_r == ST_DONE) && (!ov_r || out_tready);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  // mean anomaly: Horner step of time*rate modulo 2*pi*2^(16+F)
  logic [MODW+1:0] mr2, mr_nxt;
  always_comb begin
    mr2 = {1'b0, mr_r, 1'b0} + (tv_r[TW-1] ? (MODW+2)'(mm_r) : '0);
    if (mr2 >= MOD2_C)
      mr_nxt = mr2 - MOD2_C;
    else if (mr2 >= MOD_C)
      mr_nxt = mr2 - MOD_C;
    else
      mr_nxt = mr2;
  end

  // CORDIC fold and iteration
  logic signed [CRW-1:0] z0, dx, dy, atan_v, xf, yf;
  always_comb begin
    z0     = {{(CRW-AW){ea_r[AW-1]}}, ea_r} <<< (30 - FRAC_BITS);
    dx     = y_r >>> cnt_r[4:0];
    dy     = x_r >>> cnt_r[4:0];
    atan_v = {{(CRW-30){1'b0}}, ATAN_TAB[cnt_r[4:0]]};
    xf     = flip_r ? -x_r : x_r;
    yf     = flip_r ? -y_r : y_r;
  end

  // serial multipliers, MSB of the multiplier first
  logic signed [CW-1:0]  mc0, mc1;
  logic signed [PRW-1:0] acc0_nxt, acc1_nxt, acc0_sh, acc1_sh;
  always_comb begin
    mc0      = (state_r == ST_XY) ? c_r : s_r;
    mc1      = (state_r == ST_XY) ? s_r : c_r;
    acc0_nxt = (acc0_r <<< 1)
             + (mp0_r[AXW-1] ? {{(PRW-CW){mc0[CW-1]}}, mc0} : '0);
    acc1_nxt = (acc1_r <<< 1)
             + (mp1_r[AXW-1] ? {{(PRW-CW){mc1[CW-1]}}, mc1} : '0);
    acc0_sh  = acc0_r >>> FRAC_BITS;
    acc1_sh  = acc1_r >>> FRAC_BITS;
  end

  // residual and denominator
  logic signed [NW-1:0] es, ec, num, den_w, mag_w;
  logic                 hit;
  always_comb begin
    es    = acc0_sh[NW-1:0];
    ec    = acc1_sh[NW-1:0];
    num   = {{(NW-AW){m_r[AW-1]}}, m_r} - {{(NW-AW){ea_r[AW-1]}}, ea_r} + es;
    den_w = ONE_S - ec;
    mag_w = num[NW-1] ? -num : num;
    hit   = (steps_r != '0) && ($unsigned(mag_w) <= NW'(tol_r));
  end

  // restoring divide with quotient reduced modulo two pi on the fly
  logic [DENW:0] r2;
  logic          ge;
  logic [QMW:0]  qm2;
  logic [DENW:0] rem_w;
  logic [QMW:0]  qm_w;
  always_comb begin
    r2    = {rem_r, dv_r[DVW-1]};
    ge    = (r2 >= {1'b0, den_r});
    rem_w = ge ? (r2 - {1'b0, den_r}) : r2;
    qm2   = {qm_r, ge};
    qm_w  = (qm2 >= QM_TWO) ? (qm2 - QM_TWO) : qm2;
  end

  // Newton update
  logic signed [NW-1:0] dq, upd;
  always_comb begin
    dq  = neg_r ? -$signed({{(NW-QMW){1'b0}}, qm_r}) : $signed({{(NW-QMW){1'b0}}, qm_r});
    upd = {{(NW-AW){ea_r[AW-1]}}, ea_r} + dq;
  end

  // output fields
  logic [6:0] steps_w;
  logic [4:0] steps_o;
  logic signed [34:0] xw, yw;
  always_comb begin
    steps_w = 7'(steps_r);
    steps_o = (steps_w > 7'd31) ? 5'd31 : steps_w[4:0];
    xw      = {acc0_sh[33], acc0_sh[33:0]} - {4'b0, fo_r};
    yw      = acc1_sh[34:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_MMOD;
      ST_MMOD:  if (cnt_r == 6'(TW - 1)) state_nxt = ST_MWRAP;
      ST_MWRAP: state_nxt = ST_CINIT;
      ST_CINIT: state_nxt = ST_CORD;
      ST_CORD:  if (cnt_r == 6'(CORDIC_N - 1)) state_nxt = ST_CFIN;
      ST_CFIN:  state_nxt = ST_MUL;
      ST_MUL:   if (cnt_r == 6'(ECCW - 1)) state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (hit || (steps_r == SW'(MAX_ITER)))
          state_nxt = ST_XY;
        else
          state_nxt = ST_DIV;
      end
      ST_DIV:   if (cnt_r == 6'(DVW - 1)) state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_CINIT;
      ST_XY:    if (cnt_r == 6'(AXW - 1)) state_nxt = ST_SAT;
      ST_SAT:   state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      last_r  <= '0;
      ecc_r   <= '0;
      mm_r    <= AXW'(1) << FRAC_BITS;
      sa_r    <= AXW'(1) << FRAC_BITS;
      sb_r    <= AXW'(1) << FRAC_BITS;
      fo_r    <= '0;
      tol_r   <= TOLW'(1);
    end else begin
      state_r <= state_nxt;
      // restart the counter on every state change
      cnt_r   <= (state_nxt != state_r) ? 6'd0 : cnt_r + 6'd1;
      if (out_load) begin
        ov_r   <= 1'b1;
        last_r <= ea_r;
      end else if (out_acc) begin
        ov_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_ECC: ecc_r <= cfg_wdata[ECCW-1:0];
          REG_MM:  mm_r  <= cfg_wdata[AXW-1:0];
          REG_SA:  sa_r  <= cfg_wdata[AXW-1:0];
          REG_SB:  sb_r  <= cfg_wdata[AXW-1:0];
          REG_FO:  fo_r  <= cfg_wdata[AXW-1:0];
          REG_TOL: tol_r <= cfg_wdata[TOLW-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        tv_r <= in_tdata;
        mr_r <= '0;
      end
      ST_MMOD: begin
        mr_r <= mr_nxt[MODW-1:0];
        tv_r <= tv_r << 1;
      end
      ST_MWRAP: begin
        m_r     <= wrap_angle({{(NW-(MODW-16)){1'b0}}, mr_r[MODW-1:16]});
        ea_r    <= last_r;
        steps_r <= '0;
        conv_r  <= 1'b0;
      end
      ST_CINIT: begin
        // fold into [-pi/2, pi/2] by a half turn
        x_r <= GAIN_S;
        y_r <= '0;
        if (z0 > HALF_S) begin
          z_r    <= z0 - PI30_S;
          flip_r <= 1'b1;
        end else if (z0 < -HALF_S) begin
          z_r    <= z0 + PI30_S;
          flip_r <= 1'b1;
        end else begin
          z_r    <= z0;
          flip_r <= 1'b0;
        end
      end
      ST_CORD: begin
        if (!z_r[CRW-1]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - atan_v;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + atan_v;
        end
      end
      ST_CFIN: begin
        c_r    <= clamp_one(xf[CRW-1:30-FRAC_BITS]);
        s_r    <= clamp_one(yf[CRW-1:30-FRAC_BITS]);
        mp0_r  <= {ecc_r, {(AXW-ECCW){1'b0}}};
        mp1_r  <= {ecc_r, {(AXW-ECCW){1'b0}}};
        acc0_r <= '0;
        acc1_r <= '0;
      end
      ST_MUL, ST_XY: begin
        acc0_r <= acc0_nxt;
        acc1_r <= acc1_nxt;
        mp0_r  <= mp0_r << 1;
        mp1_r  <= mp1_r << 1;
      end
      ST_EVAL: begin
        den_r  <= den_w[DENW-1:0];
        neg_r  <= num[NW-1];
        dv_r   <= {mag_w[MAGW-1:0], {FRAC_BITS{1'b0}}};
        rem_r  <= '0;
        qm_r   <= '0;
        conv_r <= hit;
        mp0_r  <= sa_r;
        mp1_r  <= sb_r;
        acc0_r <= '0;
        acc1_r <= '0;
      end
      ST_DIV: begin
        rem_r <= rem_w[DENW-1:0];
        qm_r  <= qm_w[QMW-1:0];
        dv_r  <= dv_r << 1;
      end
      ST_UPD: begin
        ea_r    <= wrap_angle(upd);
        steps_r <= steps_r + SW'(1);
      end
      ST_SAT: begin
        px_r <= sat32(xw);
        py_r <= sat32(yw);
      end
      ST_DONE: begin
        if (out_load)
          od_r <= {7'b0, conv_r, steps_o, ea_r, py_r, px_r};
      end
      default: ;
    endcase
  end

  // checks
  logic signed [AW-1:0] o_anom;
  logic [4:0]           o_steps;
  assign o_anom  = signed'(od_r[90:64]);
  assign o_steps = od_r[95:91];

  `AST_NEXT(a_one_in_work, in_acc, !in_tready, "second item taken while busy")
  `AST_NOW(a_anom_range, ov_r, (o_anom <= PI_A) && (o_anom > -PI_A), "anomaly out of range")
  `AST_NOW(a_conv_steps, ov_r && od_r[96], o_steps != 5'd0, "converged without a step")
  `AST_NOW(a_limit_steps, ov_r && !od_r[96], o_steps == 5'(STEPS_CAP), "early stop without convergence")

endmodule
